[rtl/core/grid_contour_tracer_core_defines.svh]
// Assertion macros for the grid contour tracer core.
// Included by the top level; the checks drop out when SYNTH is defined.
`ifndef GRID_CONTOUR_TRACER_CORE_DEFINES_SVH
`define GRID_CONTOUR_TRACER_CORE_DEFINES_SVH
`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define GCT_ASSERT_IMP(lbl, clk_s, rstn_s, pre, post) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (pre) |-> (post)) \
        else $error("gct: same-cycle check failed");
// The consequent must hold in the cycle after the antecedent.
`define GCT_ASSERT_NXT(lbl, clk_s, rstn_s, pre, post) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (pre) |=> (post)) \
        else $error("gct: next-cycle check failed");
`else
`define GCT_ASSERT_IMP(lbl, clk_s, rstn_s, pre, post)
`define GCT_ASSERT_NXT(lbl, clk_s, rstn_s, pre, post)
`endif
`endif

[rtl/core/gct_pkg.sv]
// Shared types, constants and bit search helpers of the grid contour tracer.
// No dependencies; used by gct_bitmap and grid_contour_tracer_core.
package gct_pkg;

    localparam int GRID_W     = 64;
    localparam int GRID_H     = 64;
    localparam int XW         = $clog2(GRID_W);
    localparam int YW         = $clog2(GRID_H);
    localparam int VW         = 7;
    localparam int WALK_LIMIT = 4 * GRID_W * GRID_H;
    localparam int CNT_W      = $clog2(WALK_LIMIT + 1);

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_ADD    = 2'd1,
        OP_INVERT = 2'd2,
        OP_NEXT   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_RIGHT = 2'd3
    } dir_t;

    // Access to the column-major copy: one word per x, one bit per y.
    typedef struct packed {
        logic              rd;
        logic              wr;
        logic [XW-1:0]     addr;
        logic [GRID_H-1:0] wdata;
    } col_req_t;

    // Access to the row-major copy: one word per y, one bit per x.
    typedef struct packed {
        logic              rd;
        logic              wr;
        logic [YW-1:0]     addr;
        logic [GRID_W-1:0] wdata;
    } row_req_t;

    typedef struct packed {
        logic          found;
        logic [XW-1:0] idx;
    } bit_pos_t;

    // Lowest set bit of a row word.
    function automatic bit_pos_t find_lowest(input logic [GRID_W-1:0] word);
        bit_pos_t res;
        res.found = 1'b0;
        res.idx   = '0;
        for (int i = GRID_W - 1; i >= 0; i--) begin
            if (word[i])
            begin
                res.found = 1'b1;
                res.idx   = XW'(i);
            end
        end
        return res;
    endfunction

    // Highest set bit of a row word.
    function automatic bit_pos_t find_highest(input logic [GRID_W-1:0] word);
        bit_pos_t res;
        res.found = 1'b0;
        res.idx   = '0;
        for (int i = 0; i < GRID_W; i++) begin
            if (word[i])
            begin
                res.found = 1'b1;
                res.idx   = XW'(i);
            end
        end
        return res;
    endfunction

endpackage

[rtl/core/grid_contour_tracer_core.sv]
// Grid contour tracer top level: command decode, invert scan and clockwise walk.
// Depends on gct_pkg, gct_bitmap and grid_contour_tracer_core_defines.svh.
//
// Each input beat is one command. Invert scans rows upward from the start row;
// each row takes one read of the row copy, then one bit search, or three when
// the row holds a blocked cell at or right of the start column. The first
// next-vertex after reset, a clear, add or invert, or a closed trace gives the
// start corner. Every later one walks the outline, each step one bitmap word
// read and one evaluation, until the direction changes or the trace closes, then
// loads the result into the output register once that register is free. One
// command is in work at a time; the next beat is taken as soon as the result
// sits in the output register. The bitmap needs no clearing pass after reset or
// on clear: each stored word has a valid bit.
`include "grid_contour_tracer_core_defines.svh"

module grid_contour_tracer_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // cell_x [5:0], cell_y [11:6], zero fill
    input  logic [1:0]  s_axis_tuser,   // op [1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // vertex_x [6:0], vertex_y [13:7], zero fill
    output logic        m_axis_tuser    // closed [0]
);

    localparam logic [gct_pkg::XW-1:0] X_LAST = gct_pkg::XW'(gct_pkg::GRID_W - 1);
    localparam logic [gct_pkg::YW-1:0] Y_LAST = gct_pkg::YW'(gct_pkg::GRID_H - 1);

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_ADD       = 9'b000000010,
        S_INV_RD    = 9'b000000100,
        S_INV_FIRST = 9'b000001000,
        S_INV_LAST  = 9'b000010000,
        S_INV_GAP   = 9'b000100000,
        S_WRD       = 9'b001000000,
        S_WEVAL     = 9'b010000000,
        S_EMIT      = 9'b100000000
    } state_t;

    state_t                          state_reg, state_next;
    logic [gct_pkg::XW-1:0]          start_x_reg, start_x_next;
    logic [gct_pkg::YW-1:0]          start_y_reg, start_y_next;
    logic                            has_cells_reg, has_cells_next;
    logic [gct_pkg::XW-1:0]          pose_x_reg, pose_x_next;
    logic [gct_pkg::YW-1:0]          pose_y_reg, pose_y_next;
    gct_pkg::dir_t                   pose_dir_reg, pose_dir_next;
    logic                            trace_active_reg, trace_active_next;
    logic [gct_pkg::CNT_W-1:0]       walk_count_reg, walk_count_next;
    logic [gct_pkg::YW-1:0]          scan_y_reg, scan_y_next;
    logic                            m_valid_reg, m_valid_next;

    logic [gct_pkg::XW-1:0]          add_x_reg, add_x_next;
    logic [gct_pkg::YW-1:0]          add_y_reg, add_y_next;
    logic [gct_pkg::GRID_W-1:0]      inv_word_reg, inv_word_next;
    logic [gct_pkg::XW-1:0]          inv_first_reg, inv_first_next;
    logic [gct_pkg::XW-1:0]          inv_last_reg, inv_last_next;
    logic [gct_pkg::VW-1:0]          res_x_reg, res_x_next;
    logic [gct_pkg::VW-1:0]          res_y_reg, res_y_next;
    logic                            res_closed_reg, res_closed_next;
    logic [15:0]                     m_tdata_reg, m_tdata_next;
    logic                            m_tuser_reg, m_tuser_next;

    logic                            s_accept;
    gct_pkg::op_t                    in_op;
    logic [gct_pkg::XW-1:0]          in_cell_x;
    logic [gct_pkg::YW-1:0]          in_cell_y;
    logic                            in_range;
    logic                            out_load;

    logic                            bm_clear;
    gct_pkg::col_req_t               col_req;
    gct_pkg::row_req_t               row_req;
    logic [gct_pkg::GRID_H-1:0]      col_rdata;
    logic [gct_pkg::GRID_W-1:0]      row_rdata;

    // Walk step evaluation results.
    logic                            blk_d;
    logic                            blk_s;
    logic [gct_pkg::XW-1:0]          nxt_x;
    logic [gct_pkg::YW-1:0]          nxt_y;
    gct_pkg::dir_t                   nxt_dir;
    logic [gct_pkg::VW-1:0]          corner_x;
    logic [gct_pkg::VW-1:0]          corner_y;
    logic [gct_pkg::CNT_W-1:0]       cnt_inc;
    logic                            walk_close;
    logic                            x_lo, x_hi, y_lo, y_hi;

    // Invert scan searches.
    logic [gct_pkg::GRID_W-1:0]      mask_ge_start;
    logic [gct_pkg::GRID_W-1:0]      mask_gt_first;
    logic [gct_pkg::GRID_W-1:0]      mask_le_last;
    gct_pkg::bit_pos_t               first_pos;
    gct_pkg::bit_pos_t               last_pos;
    gct_pkg::bit_pos_t               gap_pos;

    gct_bitmap u_bitmap
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (bm_clear),
        .col_req   (col_req),
        .row_req   (row_req),
        .col_rdata (col_rdata),
        .row_rdata (row_rdata)
    );

    // Input beat decode.
    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign in_op         = gct_pkg::op_t'(s_axis_tuser);
    assign in_cell_x     = s_axis_tdata[5:0];
    assign in_cell_y     = s_axis_tdata[11:6];
    assign in_range      = (32'(in_cell_x) < 32'(gct_pkg::GRID_W)) &&
                           (32'(in_cell_y) < 32'(gct_pkg::GRID_H));

    // Output register.
    assign out_load      = (state_reg == S_EMIT) && (!m_valid_reg || m_axis_tready);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tuser  = m_tuser_reg;

    // Row masks and bit searches for the invert scan.
    assign mask_ge_start = {gct_pkg::GRID_W{1'b1}} << start_x_reg;
    assign mask_gt_first = ({gct_pkg::GRID_W{1'b1}} << inv_first_reg) << 1;
    assign mask_le_last  = ~(({gct_pkg::GRID_W{1'b1}} << inv_last_reg) << 1);
    assign first_pos     = gct_pkg::find_lowest(row_rdata & mask_ge_start);
    assign last_pos      = gct_pkg::find_highest(inv_word_reg & mask_gt_first);
    assign gap_pos       = gct_pkg::find_highest(~inv_word_reg & mask_gt_first & mask_le_last);

    // One walk step from the current pose; neighbors off the grid count as free.
    assign x_lo    = (pose_x_reg == '0);
    assign x_hi    = (pose_x_reg == X_LAST);
    assign y_lo    = (pose_y_reg == '0);
    assign y_hi    = (pose_y_reg == Y_LAST);
    assign cnt_inc = walk_count_reg + 1'b1;

    always_comb
    begin
        blk_d    = 1'b0;
        blk_s    = 1'b0;
        nxt_x    = pose_x_reg;
        nxt_y    = pose_y_reg;
        nxt_dir  = pose_dir_reg;
        corner_x = gct_pkg::VW'(pose_x_reg);
        corner_y = gct_pkg::VW'(pose_y_reg);
        unique case (pose_dir_reg)
            gct_pkg::DIR_UP:
            begin
                blk_d    = !y_hi && !x_lo && row_rdata[pose_x_reg - 1'b1];
                blk_s    = !y_hi && row_rdata[pose_x_reg];
                corner_y = gct_pkg::VW'(pose_y_reg) + 1'b1;
                if (blk_d)
                begin
                    nxt_x   = pose_x_reg - 1'b1;
                    nxt_y   = pose_y_reg + 1'b1;
                    nxt_dir = gct_pkg::DIR_LEFT;
                end
                else if (blk_s)
                begin
                    nxt_y   = pose_y_reg + 1'b1;
                end
                else
                begin
                    nxt_dir = gct_pkg::DIR_RIGHT;
                end
            end
            gct_pkg::DIR_DOWN:
            begin
                blk_d    = !y_lo && !x_hi && row_rdata[pose_x_reg + 1'b1];
                blk_s    = !y_lo && row_rdata[pose_x_reg];
                corner_x = gct_pkg::VW'(pose_x_reg) + 1'b1;
                if (blk_d)
                begin
                    nxt_x   = pose_x_reg + 1'b1;
                    nxt_y   = pose_y_reg - 1'b1;
                    nxt_dir = gct_pkg::DIR_RIGHT;
                end
                else if (blk_s)
                begin
                    nxt_y   = pose_y_reg - 1'b1;
                end
                else
                begin
                    nxt_dir = gct_pkg::DIR_LEFT;
                end
            end
            gct_pkg::DIR_LEFT:
            begin
                blk_d = !x_lo && !y_lo && col_rdata[pose_y_reg - 1'b1];
                blk_s = !x_lo && col_rdata[pose_y_reg];
                if (blk_d)
                begin
                    nxt_x   = pose_x_reg - 1'b1;
                    nxt_y   = pose_y_reg - 1'b1;
                    nxt_dir = gct_pkg::DIR_DOWN;
                end
                else if (blk_s)
                begin
                    nxt_x   = pose_x_reg - 1'b1;
                end
                else
                begin
                    nxt_dir = gct_pkg::DIR_UP;
                end
            end
            gct_pkg::DIR_RIGHT:
            begin
                blk_d    = !x_hi && !y_hi && col_rdata[pose_y_reg + 1'b1];
                blk_s    = !x_hi && col_rdata[pose_y_reg];
                corner_x = gct_pkg::VW'(pose_x_reg) + 1'b1;
                corner_y = gct_pkg::VW'(pose_y_reg) + 1'b1;
                if (blk_d)
                begin
                    nxt_x   = pose_x_reg + 1'b1;
                    nxt_y   = pose_y_reg + 1'b1;
                    nxt_dir = gct_pkg::DIR_UP;
                end
                else if (blk_s)
                begin
                    nxt_x   = pose_x_reg + 1'b1;
                end
                else
                begin
                    nxt_dir = gct_pkg::DIR_DOWN;
                end
            end
            default:
            begin
                nxt_dir = pose_dir_reg;
            end
        endcase
    end

    // The trace closes on return to the start facing up, or when the step budget runs out.
    assign walk_close = ((nxt_x == start_x_reg) && (nxt_y == start_y_reg) &&
                         (nxt_dir == gct_pkg::DIR_UP)) ||
                        (cnt_inc >= gct_pkg::CNT_W'(gct_pkg::WALK_LIMIT));

    // Command sequencer.
    always_comb
    begin
        state_next        = state_reg;
        start_x_next      = start_x_reg;
        start_y_next      = start_y_reg;
        has_cells_next    = has_cells_reg;
        pose_x_next       = pose_x_reg;
        pose_y_next       = pose_y_reg;
        pose_dir_next     = pose_dir_reg;
        trace_active_next = trace_active_reg;
        walk_count_next   = walk_count_reg;
        scan_y_next       = scan_y_reg;
        add_x_next        = add_x_reg;
        add_y_next        = add_y_reg;
        inv_word_next     = inv_word_reg;
        inv_first_next    = inv_first_reg;
        inv_last_next     = inv_last_reg;
        res_x_next        = res_x_reg;
        res_y_next        = res_y_reg;
        res_closed_next   = res_closed_reg;
        bm_clear          = 1'b0;
        col_req           = '0;
        row_req           = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    unique case (in_op)
                        gct_pkg::OP_CLEAR:
                        begin
                            bm_clear          = 1'b1;
                            start_x_next      = '0;
                            start_y_next      = '0;
                            has_cells_next    = 1'b0;
                            trace_active_next = 1'b0;
                        end
                        gct_pkg::OP_ADD:
                        begin
                            trace_active_next = 1'b0;
                            if (in_range)
                            begin
                                has_cells_next = 1'b1;
                                if (!has_cells_reg || (in_cell_x < start_x_reg))
                                begin
                                    start_x_next = in_cell_x;
                                    start_y_next = in_cell_y;
                                end
                                else if ((in_cell_x == start_x_reg) &&
                                         (in_cell_y < start_y_reg))
                                begin
                                    start_y_next = in_cell_y;
                                end
                                add_x_next   = in_cell_x;
                                add_y_next   = in_cell_y;
                                col_req.rd   = 1'b1;
                                col_req.addr = in_cell_x;
                                row_req.rd   = 1'b1;
                                row_req.addr = in_cell_y;
                                state_next   = S_ADD;
                            end
                        end
                        gct_pkg::OP_INVERT:
                        begin
                            trace_active_next = 1'b0;
                            scan_y_next       = start_y_reg;
                            state_next        = S_INV_RD;
                        end
                        gct_pkg::OP_NEXT:
                        begin
                            if (!trace_active_reg)
                            begin
                                trace_active_next = 1'b1;
                                pose_x_next       = start_x_reg;
                                pose_y_next       = start_y_reg;
                                pose_dir_next     = gct_pkg::DIR_UP;
                                walk_count_next   = '0;
                                res_x_next        = gct_pkg::VW'(start_x_reg);
                                res_y_next        = gct_pkg::VW'(start_y_reg);
                                res_closed_next   = 1'b0;
                                state_next        = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_WRD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // Read-modify-write of both bitmap copies.
            S_ADD:
            begin
                col_req.wr                = 1'b1;
                col_req.addr              = add_x_reg;
                col_req.wdata             = col_rdata;
                col_req.wdata[add_y_reg]  = 1'b1;
                row_req.wr                = 1'b1;
                row_req.addr              = add_y_reg;
                row_req.wdata             = row_rdata;
                row_req.wdata[add_x_reg]  = 1'b1;
                state_next                = S_IDLE;
            end

            S_INV_RD:
            begin
                row_req.rd   = 1'b1;
                row_req.addr = scan_y_reg;
                state_next   = S_INV_FIRST;
            end

            // First blocked cell at or right of the start column.
            S_INV_FIRST:
            begin
                inv_word_next  = row_rdata;
                inv_first_next = first_pos.idx;
                if (first_pos.found)
                begin
                    state_next = S_INV_LAST;
                end
                else if (scan_y_reg == Y_LAST)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    scan_y_next = scan_y_reg + 1'b1;
                    state_next  = S_INV_RD;
                end
            end

            // Rightmost blocked cell past the first one.
            S_INV_LAST:
            begin
                inv_last_next = last_pos.found ? last_pos.idx : inv_first_reg;
                state_next    = S_INV_GAP;
            end

            // Rightmost free cell between them; the start goes just right of it.
            S_INV_GAP:
            begin
                if (gap_pos.found)
                begin
                    start_x_next = gap_pos.idx + 1'b1;
                    start_y_next = scan_y_reg;
                    state_next   = S_IDLE;
                end
                else if (scan_y_reg == Y_LAST)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    scan_y_next = scan_y_reg + 1'b1;
                    state_next  = S_INV_RD;
                end
            end

            // Fetch the one word that holds both neighbors of this pose.
            S_WRD:
            begin
                unique case (pose_dir_reg)
                    gct_pkg::DIR_UP:
                    begin
                        row_req.rd   = 1'b1;
                        row_req.addr = pose_y_reg + 1'b1;
                    end
                    gct_pkg::DIR_DOWN:
                    begin
                        row_req.rd   = 1'b1;
                        row_req.addr = pose_y_reg - 1'b1;
                    end
                    gct_pkg::DIR_LEFT:
                    begin
                        col_req.rd   = 1'b1;
                        col_req.addr = pose_x_reg - 1'b1;
                    end
                    gct_pkg::DIR_RIGHT:
                    begin
                        col_req.rd   = 1'b1;
                        col_req.addr = pose_x_reg + 1'b1;
                    end
                    default:
                    begin
                        col_req.rd = 1'b0;
                    end
                endcase
                state_next = S_WEVAL;
            end

            S_WEVAL:
            begin
                walk_count_next = cnt_inc;
                if (walk_close)
                begin
                    trace_active_next = 1'b0;
                    res_x_next        = '0;
                    res_y_next        = '0;
                    res_closed_next   = 1'b1;
                    state_next        = S_EMIT;
                end
                else
                begin
                    pose_x_next   = nxt_x;
                    pose_y_next   = nxt_y;
                    pose_dir_next = nxt_dir;
                    if (nxt_dir == pose_dir_reg)
                    begin
                        state_next = S_WRD;
                    end
                    else
                    begin
                        res_x_next      = corner_x;
                        res_y_next      = corner_y;
                        res_closed_next = 1'b0;
                        state_next      = S_EMIT;
                    end
                end
            end

            S_EMIT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register next values.
    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_tdata_next = m_tdata_reg;
        m_tuser_next = m_tuser_reg;
        if (out_load)
        begin
            m_valid_next = 1'b1;
            m_tdata_next = {2'b00, res_y_reg, res_x_reg};
            m_tuser_next = res_closed_reg;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            start_x_reg      <= '0;
            start_y_reg      <= '0;
            has_cells_reg    <= 1'b0;
            pose_x_reg       <= '0;
            pose_y_reg       <= '0;
            pose_dir_reg     <= gct_pkg::DIR_UP;
            trace_active_reg <= 1'b0;
            walk_count_reg   <= '0;
            scan_y_reg       <= '0;
            m_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            start_x_reg      <= start_x_next;
            start_y_reg      <= start_y_next;
            has_cells_reg    <= has_cells_next;
            pose_x_reg       <= pose_x_next;
            pose_y_reg       <= pose_y_next;
            pose_dir_reg     <= pose_dir_next;
            trace_active_reg <= trace_active_next;
            walk_count_reg   <= walk_count_next;
            scan_y_reg       <= scan_y_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        add_x_reg      <= add_x_next;
        add_y_reg      <= add_y_next;
        inv_word_reg   <= inv_word_next;
        inv_first_reg  <= inv_first_next;
        inv_last_reg   <= inv_last_next;
        res_x_reg      <= res_x_next;
        res_y_reg      <= res_y_next;
        res_closed_reg <= res_closed_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    // A result is only moved into the output register when that register is free.
    `GCT_ASSERT_IMP(a_out_slot_free, clk, rst_n, out_load, !m_valid_reg || m_axis_tready)
    // A next-vertex command always yields a result, so the block never stays idle on it.
    `GCT_ASSERT_NXT(a_next_goes_busy, clk, rst_n, s_accept && (in_op == gct_pkg::OP_NEXT), state_reg != S_IDLE)
    // The walk only runs inside an active trace.
    `GCT_ASSERT_IMP(a_walk_in_trace, clk, rst_n, state_reg == S_WEVAL, trace_active_reg)
    // A closing step ends the trace.
    `GCT_ASSERT_NXT(a_close_ends_trace, clk, rst_n, (state_reg == S_WEVAL) && walk_close, !trace_active_reg)

endmodule

[rtl/core/gct_bitmap.sv]
// Blocked-cell bitmap held twice: by column and by row, each with a word valid bit.
// Depends on gct_pkg for the geometry and the request structs.
module gct_bitmap
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      clear,
    input  gct_pkg::col_req_t         col_req,
    input  gct_pkg::row_req_t         row_req,
    output logic [gct_pkg::GRID_H-1:0] col_rdata,
    output logic [gct_pkg::GRID_W-1:0] row_rdata
);

    logic [gct_pkg::GRID_H-1:0] col_mem [gct_pkg::GRID_W];
    logic [gct_pkg::GRID_W-1:0] row_mem [gct_pkg::GRID_H];

    logic [gct_pkg::GRID_W-1:0] col_vld_reg;
    logic [gct_pkg::GRID_H-1:0] row_vld_reg;
    logic                       col_rvld_reg;
    logic                       row_rvld_reg;
    logic [gct_pkg::GRID_H-1:0] col_rdata_reg;
    logic [gct_pkg::GRID_W-1:0] row_rdata_reg;

    // Memory arrays: one write and one registered read per copy.
    always_ff @(posedge clk)
    begin
        if (col_req.wr)
        begin
            col_mem[col_req.addr] <= col_req.wdata;
        end
        if (col_req.rd)
        begin
            col_rdata_reg <= col_mem[col_req.addr];
        end
        if (row_req.wr)
        begin
            row_mem[row_req.addr] <= row_req.wdata;
        end
        if (row_req.rd)
        begin
            row_rdata_reg <= row_mem[row_req.addr];
        end
    end

    // Word valid bits: a clear drops all of them at once.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_vld_reg  <= '0;
            row_vld_reg  <= '0;
            col_rvld_reg <= 1'b0;
            row_rvld_reg <= 1'b0;
        end
        else
        begin
            if (clear)
            begin
                col_vld_reg <= '0;
                row_vld_reg <= '0;
            end
            else
            begin
                if (col_req.wr)
                begin
                    col_vld_reg[col_req.addr] <= 1'b1;
                end
                if (row_req.wr)
                begin
                    row_vld_reg[row_req.addr] <= 1'b1;
                end
            end
            if (col_req.rd)
            begin
                col_rvld_reg <= col_vld_reg[col_req.addr];
            end
            if (row_req.rd)
            begin
                row_rvld_reg <= row_vld_reg[row_req.addr];
            end
        end
    end

    // A word that was never written since the last clear reads as all free.
    assign col_rdata = col_rvld_reg ? col_rdata_reg : '0;
    assign row_rdata = row_rvld_reg ? row_rdata_reg : '0;

endmodule
